[sv/held_waveform_pattern_generator_assert.svh]
// Assertion macros shared by the pattern generator modules.
// With SYNTH defined every macro expands to nothing.
`ifndef HELD_WAVEFORM_PATTERN_GENERATOR_ASSERT_SVH
`define HELD_WAVEFORM_PATTERN_GENERATOR_ASSERT_SVH

`ifndef SYNTH

// Condition must hold at every clock edge outside reset.
`define HWPG_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("hwpg: invariant violated");

// When the antecedent holds, the consequent must hold in the next cycle.
`define HWPG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hwpg: next-cycle check failed");

`else

`define HWPG_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define HWPG_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[sv/hwpg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package hwpg_pkg;

    // Default build parameters
    localparam int HOLD_LEN_DEF        = 50;
    localparam int SINE_TABLE_BITS_DEF = 10;

    // Field and register widths
    localparam int SAMPLE_W = 16;
    localparam int MODE_W   = 3;
    localparam int SEED_W   = 32;
    localparam int ROM_W    = 16;

    // Configuration register indexes
    localparam logic REG_PATTERN_MODE = 1'b0;
    localparam logic REG_LFSR_SEED    = 1'b1;

    // Pattern constants
    localparam logic [SAMPLE_W-1:0] SQUARE_HIGH = 16'hF000;
    localparam logic [SAMPLE_W-1:0] SQUARE_LOW  = 16'h1000;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX  = 16'hFFFF;
    localparam logic [SAMPLE_W:0]   MID_LEVEL   = 17'h08000;
    localparam logic [SAMPLE_W:0]   FULL_PHASE  = 17'h10000;
    localparam logic [SAMPLE_W:0]   TRI_SLOPE   = 17'd131070;
    localparam logic [SEED_W-1:0]   LFSR_MASK   = 32'h80200003;
    localparam logic [SEED_W-1:0]   SEED_RESET  = 32'h00000001;
    localparam logic [63:0]         HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [MODE_W-1:0] {
        MODE_SINE     = 3'd0,
        MODE_SQUARE   = 3'd1,
        MODE_TRIANGLE = 3'd2,
        MODE_SAWTOOTH = 3'd3,
        MODE_RANDOM   = 3'd4
    } pattern_mode_t;

    // Word handed from the front stage to the shaping stage
    typedef struct packed {
        logic                fresh;
        logic [MODE_W-1:0]   mode;
        logic [SAMPLE_W-1:0] phase;
        logic                lower_half;
        logic [ROM_W-1:0]    rom_data;
        logic [SAMPLE_W-1:0] noise_top;
    } s1_word_t;

    // Unsigned 64-bit quotient by shift and subtract; elaboration only
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Sine in Q30 for x in [0, pi/2], alternating Taylor series.
    // Evaluated at elaboration only.
    function automatic logic [63:0] sine_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] divisor;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int n = 1; n <= 10; n++) begin
            divisor = 64'((2 * n) * (2 * n + 1));
            term    = div_u64((term * x2) >> 30, divisor);
            if ((n & 1) == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        return sum;
    endfunction

    // One quarter-wave table entry; quarter_bits = table bits - 2
    function automatic logic [ROM_W-1:0] sine_entry(input int j, input int quarter_bits);
        logic [63:0] x;
        logic [63:0] v;
        x = (HALF_PI_Q30 * 64'(j)) >> quarter_bits;
        v = (sine_q30(x) * 64'd32768 + (64'd1 << 29)) >> 30;
        if (v > 64'd32768 || j == (1 << quarter_bits))
            v = 64'd32768;
        return v[ROM_W-1:0];
    endfunction

endpackage

`default_nettype wire

[sv/held_waveform_pattern_generator.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  tick
// output    out        out_valid/out_stall  sample[15:0], new_value
// config    in         wr_en (no wait)      wr_index, wr_data[31:0]
//
// One word per clock sustained while out_stall is low; an accepted word passes
// through the front register (with the sine table read), then the output
// register, and leaves it while out_stall is low. Reset loads the noise
// register with 1 and clears phase, hold count and held sample; no clearing
// pass. Output stall holds the output word and backs up to in_stall once the
// front word is also full.
module held_waveform_pattern_generator #(
    parameter int HOLD_LEN        = hwpg_pkg::HOLD_LEN_DEF,
    parameter int SINE_TABLE_BITS = hwpg_pkg::SINE_TABLE_BITS_DEF
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             in_valid,
    output logic                            in_stall,
    input  wire                             tick,
    output logic                            out_valid,
    input  wire                             out_stall,
    output logic [hwpg_pkg::SAMPLE_W-1:0]   sample,
    output logic                            new_value,
    input  wire                             wr_en,
    input  wire                             wr_index,
    input  wire  [hwpg_pkg::SEED_W-1:0]     wr_data
);
    import hwpg_pkg::*;

    logic [MODE_W-1:0] mode_reg, mode_next;
    logic              seed_load;
    logic              out_free;
    logic              s1_valid;
    s1_word_t          s1_word;

    // Configuration registers
    assign seed_load = wr_en && (wr_index == REG_LFSR_SEED);

    always_comb
    begin
        mode_next = mode_reg;
        if (wr_en && (wr_index == REG_PATTERN_MODE))
            mode_next = wr_data[MODE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_SINE;
        else
            mode_reg <= mode_next;
    end

    hwpg_front #(
        .HOLD_LEN        (HOLD_LEN),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .tick      (tick),
        .mode      (mode_reg),
        .seed_load (seed_load),
        .seed      (wr_data),
        .out_free  (out_free),
        .s1_valid  (s1_valid),
        .s1_word   (s1_word)
    );

    hwpg_shape u_shape (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid),
        .s1_word   (s1_word),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sample    (sample),
        .new_value (new_value)
    );

endmodule

`default_nettype wire

[sv/hwpg_front.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "held_waveform_pattern_generator_assert.svh"

// Front stage: hold counter, phase, noise register and sine table read.
// Captures one word per accepted input.
module hwpg_front #(
    parameter int HOLD_LEN        = hwpg_pkg::HOLD_LEN_DEF,
    parameter int SINE_TABLE_BITS = hwpg_pkg::SINE_TABLE_BITS_DEF
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             in_valid,
    output logic                            in_stall,
    input  wire                             tick,
    input  wire  [hwpg_pkg::MODE_W-1:0]     mode,
    input  wire                             seed_load,
    input  wire  [hwpg_pkg::SEED_W-1:0]     seed,
    input  wire                             out_free,
    output logic                            s1_valid,
    output hwpg_pkg::s1_word_t              s1_word
);
    import hwpg_pkg::*;

    localparam int HOLD_W     = (HOLD_LEN > 1) ? $clog2(HOLD_LEN) : 1;
    localparam int QUARTER_B  = SINE_TABLE_BITS - 2;
    localparam int ADDR_W     = SINE_TABLE_BITS - 1;
    localparam int ROM_DEPTH  = (1 << QUARTER_B) + 1;

    localparam logic [HOLD_W-1:0]   HOLD_LAST = HOLD_W'(HOLD_LEN - 1);
    localparam logic [SAMPLE_W-1:0] PHASE_INC = SAMPLE_W'(HOLD_LEN);
    localparam logic [ADDR_W-1:0]   QUARTER_N = ADDR_W'(1 << QUARTER_B);

    typedef logic [ROM_W-1:0] rom_t [ROM_DEPTH];

    function automatic rom_t build_rom();
        rom_t r;
        for (int j = 0; j < ROM_DEPTH; j++)
            r[j] = sine_entry(j, QUARTER_B);
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic [HOLD_W-1:0]   hold_reg,   hold_next;
    logic [SAMPLE_W-1:0] phase_reg,  phase_next;
    logic [SEED_W-1:0]   noise_reg,  noise_next;
    logic                valid_reg,  valid_next;
    logic                fresh_reg;
    logic [MODE_W-1:0]   mode_reg;
    logic [SAMPLE_W-1:0] phase_cap_reg;
    logic                lower_reg;
    logic [ROM_W-1:0]    rom_reg;
    logic [SAMPLE_W-1:0] noise_top_reg;

    logic                accept;
    logic                start;
    logic [SEED_W-1:0]   noise_step;
    logic [QUARTER_B-1:0] rom_j;
    logic [ADDR_W-1:0]   rom_addr;

    // Handshake: a word moves on when the shaping stage can take it
    assign in_stall = valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;
    assign start    = tick && (hold_reg == '0);

    // Galois step, shifting right
    assign noise_step = noise_reg[0] ? ((noise_reg >> 1) ^ LFSR_MASK) : (noise_reg >> 1);

    // Quarter-wave address, mirrored in odd quadrants
    assign rom_j    = phase_reg[SAMPLE_W-3 -: QUARTER_B];
    assign rom_addr = phase_reg[SAMPLE_W-2] ? (QUARTER_N - ADDR_W'(rom_j)) : ADDR_W'(rom_j);

    // Next state of counter, phase and noise
    always_comb
    begin
        hold_next  = hold_reg;
        phase_next = phase_reg;
        noise_next = noise_reg;
        if (seed_load)
        begin
            noise_next = (seed == '0) ? SEED_RESET : seed;
        end
        else if (accept && tick)
        begin
            hold_next = (hold_reg == HOLD_LAST) ? '0 : hold_reg + 1'b1;
            if (start)
            begin
                unique case (mode)
                    MODE_SINE, MODE_SQUARE, MODE_TRIANGLE, MODE_SAWTOOTH:
                        phase_next = phase_reg + PHASE_INC;
                    MODE_RANDOM:
                        noise_next = noise_step;
                    default:
                        phase_next = phase_reg;
                endcase
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (out_free)
            valid_next = 1'b0;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg  <= '0;
            phase_reg <= '0;
            noise_reg <= SEED_RESET;
            valid_reg <= 1'b0;
        end
        else
        begin
            hold_reg  <= hold_next;
            phase_reg <= phase_next;
            noise_reg <= noise_next;
            valid_reg <= valid_next;
        end
    end

    // Word capture and registered table read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fresh_reg     <= start;
            mode_reg      <= mode;
            phase_cap_reg <= phase_reg;
            lower_reg     <= phase_reg[SAMPLE_W-1];
            rom_reg       <= SINE_ROM[rom_addr];
            noise_top_reg <= noise_next[SEED_W-1 -: SAMPLE_W];
        end
    end

    assign s1_valid            = valid_reg;
    assign s1_word.fresh       = fresh_reg;
    assign s1_word.mode        = mode_reg;
    assign s1_word.phase       = phase_cap_reg;
    assign s1_word.lower_half  = lower_reg;
    assign s1_word.rom_data    = rom_reg;
    assign s1_word.noise_top   = noise_top_reg;

    `HWPG_ASSERT_ALWAYS(a_hold_range, clk, rst_n, hold_reg <= HOLD_LAST)
    `HWPG_ASSERT_ALWAYS(a_noise_nonzero, clk, rst_n, noise_reg != '0)
    `HWPG_ASSERT_NEXT(a_phase_quiet, clk, rst_n, !(accept && start), $stable(phase_reg))

endmodule

`default_nettype wire

[sv/hwpg_shape.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "held_waveform_pattern_generator_assert.svh"

// Shaping stage: turns the captured word into the pattern value,
// keeps the held sample and drives the output register.
module hwpg_shape (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             s1_valid,
    input  hwpg_pkg::s1_word_t              s1_word,
    output logic                            out_free,
    output logic                            out_valid,
    input  wire                             out_stall,
    output logic [hwpg_pkg::SAMPLE_W-1:0]   sample,
    output logic                            new_value
);
    import hwpg_pkg::*;

    logic [SAMPLE_W-1:0]   held_reg,   held_next;
    logic                  valid_reg,  valid_next;
    logic [SAMPLE_W-1:0]   sample_reg;
    logic                  new_reg;

    logic                  load;
    logic [SAMPLE_W:0]     sine_sum;
    logic [SAMPLE_W-1:0]   sine_val;
    logic [SAMPLE_W:0]     tri_x;
    logic [2*SAMPLE_W+1:0] tri_prod;
    logic [SAMPLE_W-1:0]   square_val;

    assign out_free = !valid_reg || !out_stall;
    assign load     = s1_valid && out_free;

    // Sine: offset quarter-wave value, saturated at full scale
    assign sine_sum = s1_word.lower_half ? (MID_LEVEL - (SAMPLE_W+1)'(s1_word.rom_data))
                                         : (MID_LEVEL + (SAMPLE_W+1)'(s1_word.rom_data));
    assign sine_val = sine_sum[SAMPLE_W] ? SAMPLE_MAX : sine_sum[SAMPLE_W-1:0];

    // Triangle: distance from zero phase, scaled by 2*0xFFFF / 65536
    assign tri_x    = s1_word.phase[SAMPLE_W-1] ? (FULL_PHASE - (SAMPLE_W+1)'(s1_word.phase))
                                                : (SAMPLE_W+1)'(s1_word.phase);
    assign tri_prod = TRI_SLOPE * tri_x;

    assign square_val = s1_word.phase[SAMPLE_W-1] ? SQUARE_HIGH : SQUARE_LOW;

    // New held value at the start of a hold period
    always_comb
    begin
        held_next = held_reg;
        if (load && s1_word.fresh)
        begin
            unique case (s1_word.mode)
                MODE_SINE:     held_next = sine_val;
                MODE_SQUARE:   held_next = square_val;
                MODE_TRIANGLE: held_next = tri_prod[2*SAMPLE_W-1:SAMPLE_W];
                MODE_SAWTOOTH: held_next = s1_word.phase;
                MODE_RANDOM:   held_next = s1_word.noise_top;
                default:       held_next = held_reg;
            endcase
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            held_reg  <= held_next;
            valid_reg <= valid_next;
        end
    end

    // Output word register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sample_reg <= held_next;
            new_reg    <= s1_word.fresh;
        end
    end

    assign out_valid = valid_reg;
    assign sample    = sample_reg;
    assign new_value = new_reg;

    `HWPG_ASSERT_NEXT(a_held_quiet, clk, rst_n, !(load && s1_word.fresh), $stable(held_reg))
    `HWPG_ASSERT_ALWAYS(a_out_is_held, clk, rst_n, !valid_reg || (sample_reg == held_reg))

endmodule

`default_nettype wire
